// File: rtl/sqte_pkg.sv
// ----------------------------------------------------------------------------
// sqte_pkg
// Shared types and constants of the SARSA table engine: word layouts,
// register map, fixed-point helpers.
// ----------------------------------------------------------------------------
package sqte_pkg;

	localparam int DEF_GRID_ROWS   = 32;
	localparam int DEF_GRID_COLS   = 32;
	localparam int DEF_VALUE_WIDTH = 32;

	localparam int ROW_W      = 5;
	localparam int ACT_W      = 2;
	localparam int FRAC_W     = 16;
	localparam int FACTOR_W   = 17;
	localparam int REWARD_W   = 32;
	localparam int OUT_VAL_W  = 32;
	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;
	localparam int ACC_W      = 64;

	localparam logic [FACTOR_W-1:0] ONE_Q16 = 17'd65536;

	localparam logic [FACTOR_W-1:0] RST_LEARNING_RATE = 17'd6554;
	localparam logic [FACTOR_W-1:0] RST_DISCOUNT      = 17'd58982;
	localparam logic [FACTOR_W-1:0] RST_EXPLORE_RATE  = 17'd6554;

	localparam logic [1:0] REG_LEARNING_RATE = 2'd0;
	localparam logic [1:0] REG_DISCOUNT      = 2'd1;
	localparam logic [1:0] REG_EXPLORE_RATE  = 2'd2;

	localparam logic OP_CHOOSE = 1'b0;
	localparam logic OP_UPDATE = 1'b1;

	typedef struct packed {
		logic                       operation;
		logic [ROW_W-1:0]           state_row;
		logic [ROW_W-1:0]           state_col;
		logic [ACT_W-1:0]           taken_action;
		logic signed [REWARD_W-1:0] reward;
		logic [ROW_W-1:0]           next_row;
		logic [ROW_W-1:0]           next_col;
		logic [ACT_W-1:0]           next_action;
		logic [FRAC_W-1:0]          random_fraction;
		logic [ACT_W-1:0]           random_action;
	} in_word_t;

	typedef struct packed {
		logic [ACT_W-1:0]            chosen_action;
		logic                        explored;
		logic signed [OUT_VAL_W-1:0] upd_value;
	} out_word_t;

	typedef struct packed {
		logic [FACTOR_W-1:0] learning_rate;
		logic [FACTOR_W-1:0] discount;
		logic [FACTOR_W-1:0] explore_rate;
	} cfg_t;

	typedef struct packed {
		logic val_we;
		logic vis_we;
		logic vis_bit;
	} store_ctrl_t;

	// saturate a 65-bit sum to the signed 64-bit range
	function automatic logic signed [ACC_W-1:0] sat64(input logic signed [ACC_W:0] v);
		if (v[ACC_W] != v[ACC_W-1])
			return v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		return v[ACC_W-1:0];
	endfunction

endpackage

// File: rtl/sqte_regs.sv
// ----------------------------------------------------------------------------
// sqte_regs
// APB-style register file: learning rate, discount and explore rate.
// ----------------------------------------------------------------------------
module sqte_regs
	import sqte_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.learning_rate <= RST_LEARNING_RATE;
			cfg_q.discount      <= RST_DISCOUNT;
			cfg_q.explore_rate  <= RST_EXPLORE_RATE;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_LEARNING_RATE: cfg_q.learning_rate <= pwdata[FACTOR_W-1:0];
				REG_DISCOUNT:      cfg_q.discount      <= pwdata[FACTOR_W-1:0];
				REG_EXPLORE_RATE:  cfg_q.explore_rate  <= pwdata[FACTOR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_LEARNING_RATE: prdata = CFG_DATA_W'(cfg_q.learning_rate);
			REG_DISCOUNT:      prdata = CFG_DATA_W'(cfg_q.discount);
			REG_EXPLORE_RATE:  prdata = CFG_DATA_W'(cfg_q.explore_rate);
			default:           prdata = '0;
		endcase
	end

endmodule

// File: rtl/sqte_store.sv
// ----------------------------------------------------------------------------
// sqte_store
// Action value memory (four entries per cell) and visited-bit memory,
// one write and one registered read each per cycle.
// ----------------------------------------------------------------------------
module sqte_store
	import sqte_pkg::*;
#(
	parameter int CELLS       = DEF_GRID_ROWS * DEF_GRID_COLS,
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
	localparam int CELL_W     = $clog2(CELLS),
	localparam int VA_W       = CELL_W + ACT_W
) (
	input  logic                          clk,
	input  store_ctrl_t                   ctrl,
	input  logic [VA_W-1:0]               val_addr,
	input  logic signed [VALUE_WIDTH-1:0] val_wdata,
	output logic signed [VALUE_WIDTH-1:0] val_rdata,
	input  logic [CELL_W-1:0]             vis_addr,
	output logic                          vis_rdata
);

	logic [VALUE_WIDTH-1:0] value_mem [CELLS*4];
	logic                   vis_mem   [CELLS];

	always_ff @(posedge clk) begin
		if (ctrl.val_we)
			value_mem[val_addr] <= val_wdata;
		val_rdata <= value_mem[val_addr];
	end

	always_ff @(posedge clk) begin
		if (ctrl.vis_we)
			vis_mem[vis_addr] <= ctrl.vis_bit;
		vis_rdata <= vis_mem[vis_addr];
	end

endmodule

// File: rtl/sqte_engine.sv
// ----------------------------------------------------------------------------
// sqte_engine
// Sequencer and datapath: clear sweep, epsilon-greedy choose over four
// reads, SARSA update through one shared Q1.16 scaling multiplier.
// ----------------------------------------------------------------------------
module sqte_engine
	import sqte_pkg::*;
#(
	parameter int GRID_ROWS   = DEF_GRID_ROWS,
	parameter int GRID_COLS   = DEF_GRID_COLS,
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
	localparam int CELLS      = GRID_ROWS * GRID_COLS,
	localparam int CELL_W     = $clog2(CELLS),
	localparam int VA_W       = CELL_W + ACT_W
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cfg_t                          cfg,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  in_word_t                      req,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output out_word_t                     rsp,
	output logic                          clearing,
	output store_ctrl_t                   store_ctrl,
	output logic [VA_W-1:0]               val_addr,
	output logic signed [VALUE_WIDTH-1:0] val_wdata,
	input  logic signed [VALUE_WIDTH-1:0] val_rdata,
	output logic [CELL_W-1:0]             vis_addr,
	input  logic                          vis_rdata
);

	localparam logic [3:0] ST_CLEAR   = 4'd0;
	localparam logic [3:0] ST_IDLE    = 4'd1;
	localparam logic [3:0] ST_CHOOSE  = 4'd2;
	localparam logic [3:0] ST_U_RD0   = 4'd3;
	localparam logic [3:0] ST_U_RD1   = 4'd4;
	localparam logic [3:0] ST_U_RD2   = 4'd5;
	localparam logic [3:0] ST_MUL_A   = 4'd6;
	localparam logic [3:0] ST_MUL_B   = 4'd7;
	localparam logic [3:0] ST_TD_R    = 4'd8;
	localparam logic [3:0] ST_TD_OLD  = 4'd9;
	localparam logic [3:0] ST_NV      = 4'd10;
	localparam logic [3:0] ST_DONE    = 4'd11;

	localparam logic [2:0]      CH_LAST  = 3'd4;
	localparam logic [VA_W-1:0] CLR_LAST = VA_W'(CELLS * 4 - 1);

	function automatic logic [CELL_W-1:0] cell_of(input logic [ROW_W-1:0] row,
	                                              input logic [ROW_W-1:0] col);
		logic [31:0] r;
		logic [31:0] c;
		r = (32'(row) > 32'(GRID_ROWS - 1)) ? 32'(GRID_ROWS - 1) : 32'(row);
		c = (32'(col) > 32'(GRID_COLS - 1)) ? 32'(GRID_COLS - 1) : 32'(col);
		return CELL_W'(r * 32'(GRID_COLS) + c);
	endfunction

	function automatic logic signed [VALUE_WIDTH-1:0] clamp_value(
		input logic signed [ACC_W:0] v);
		if ((&v[ACC_W:VALUE_WIDTH-1]) || !(|v[ACC_W:VALUE_WIDTH-1]))
			return v[VALUE_WIDTH-1:0];
		return {v[ACC_W], {(VALUE_WIDTH-1){~v[ACC_W]}}};
	endfunction

	// control
	logic [3:0]      state_q;
	logic [2:0]      cnt_q;
	logic [VA_W-1:0] clr_q;
	logic            mul_pass_q;   // 0: gamma * Q(s',a'), 1: alpha * td
	logic            rsp_valid_q;

	// payload
	in_word_t                      item_q;
	logic [CELL_W-1:0]             s_cell_q;
	logic [CELL_W-1:0]             sn_cell_q;
	logic                          visited_q;
	logic [ACT_W-1:0]              best_act_q;
	logic signed [VALUE_WIDTH-1:0] best_val_q;
	logic signed [VALUE_WIDTH-1:0] oldv_q;
	logic signed [ACC_W-1:0]       acc_q;
	logic signed [ACC_W-1:0]       mul_hi_q;
	logic [FACTOR_W-1:0]           mul_lo_q;
	out_word_t                     res_q;
	out_word_t                     rsp_q;

	logic                          accept;
	logic                          rsp_free;
	logic                          better;
	logic                          explore;
	logic [FACTOR_W-1:0]           alpha;
	logic [FACTOR_W-1:0]           gamma;
	logic [FACTOR_W-1:0]           k_sel;
	logic signed [FACTOR_W:0]      k_s;
	logic signed [ACC_W-17:0]      hi_s;
	logic signed [ACC_W+1:0]       hi_prod;
	logic [32:0]                   lo_prod;
	logic signed [REWARD_W-1:0]    reward_s;
	logic signed [ACC_W-1:0]       td_r;
	logic signed [ACC_W-1:0]       td_old;
	logic signed [VALUE_WIDTH-1:0] nv;
	logic [ACT_W-1:0]              greedy_act;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign clearing  = (state_q == ST_CLEAR);

	// datapath
	always_comb begin
		better     = val_rdata > best_val_q;
		greedy_act = better ? ACT_W'(cnt_q - 3'd1) : best_act_q;
		explore    = ({1'b0, item_q.random_fraction} < cfg.explore_rate) || !visited_q;
		alpha      = (cfg.learning_rate > ONE_Q16) ? ONE_Q16 : cfg.learning_rate;
		gamma      = (cfg.discount > ONE_Q16) ? ONE_Q16 : cfg.discount;
		k_sel      = mul_pass_q ? alpha : gamma;
		k_s        = {1'b0, k_sel};
		hi_s       = acc_q[ACC_W-1:16];
		hi_prod    = k_s * hi_s;
		// low half: round to nearest, ties up
		lo_prod    = 33'(k_sel) * 33'(acc_q[15:0]) + 33'd32768;
		reward_s   = item_q.reward;
		td_r       = sat64((ACC_W+1)'(reward_s) + (ACC_W+1)'(acc_q));
		// exact difference then saturate; covers the most negative old value
		td_old     = sat64((ACC_W+1)'(acc_q) - (ACC_W+1)'(oldv_q));
		nv         = clamp_value((ACC_W+1)'(oldv_q) + (ACC_W+1)'(acc_q));
	end

	// memory port steering
	always_comb begin
		store_ctrl = '0;
		val_addr   = {s_cell_q, cnt_q[ACT_W-1:0]};
		val_wdata  = nv;
		vis_addr   = s_cell_q;
		unique case (state_q)
			ST_CLEAR: begin
				store_ctrl.val_we = 1'b1;
				store_ctrl.vis_we = 1'b1;
				val_addr          = clr_q;
				val_wdata         = '0;
				vis_addr          = clr_q[VA_W-1:ACT_W];
			end
			ST_U_RD0: begin
				store_ctrl.vis_we  = 1'b1;
				store_ctrl.vis_bit = 1'b1;
				val_addr           = {s_cell_q, item_q.taken_action};
			end
			ST_U_RD1: begin
				store_ctrl.vis_we  = 1'b1;
				store_ctrl.vis_bit = 1'b1;
				val_addr           = {sn_cell_q, item_q.next_action};
				vis_addr           = sn_cell_q;
			end
			ST_NV: begin
				store_ctrl.val_we = 1'b1;
				val_addr          = {s_cell_q, item_q.taken_action};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			clr_q       <= '0;
			mul_pass_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && rsp_free)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_LAST)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					cnt_q      <= '0;
					mul_pass_q <= 1'b0;
					if (accept)
						state_q <= (req.operation == OP_UPDATE) ? ST_U_RD0 : ST_CHOOSE;
				end
				ST_CHOOSE: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == CH_LAST)
						state_q <= ST_DONE;
				end
				ST_U_RD0:  state_q <= ST_U_RD1;
				ST_U_RD1:  state_q <= ST_U_RD2;
				ST_U_RD2:  state_q <= ST_MUL_A;
				ST_MUL_A:  state_q <= ST_MUL_B;
				ST_MUL_B:  state_q <= mul_pass_q ? ST_NV : ST_TD_R;
				ST_TD_R:   state_q <= ST_TD_OLD;
				ST_TD_OLD: begin
					mul_pass_q <= 1'b1;
					state_q    <= ST_MUL_A;
				end
				ST_NV:     state_q <= ST_DONE;
				ST_DONE: begin
					if (rsp_free)
						state_q <= ST_IDLE;
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q    <= req;
			s_cell_q  <= cell_of(req.state_row, req.state_col);
			sn_cell_q <= cell_of(req.next_row, req.next_col);
		end
		if (state_q == ST_DONE && rsp_free)
			rsp_q <= res_q;
		case (state_q)
			ST_CHOOSE: begin
				// read data is registered, so it lags the issued address
				if (cnt_q == 3'd1) begin
					visited_q  <= vis_rdata;
					best_act_q <= '0;
					best_val_q <= val_rdata;
				end else if (cnt_q != 3'd0) begin
					best_act_q <= greedy_act;
					if (better)
						best_val_q <= val_rdata;
				end
				if (cnt_q == CH_LAST) begin
					res_q.chosen_action <= explore ? item_q.random_action : greedy_act;
					res_q.explored      <= explore;
					res_q.upd_value     <= '0;
				end
			end
			ST_U_RD1:  oldv_q <= val_rdata;
			ST_U_RD2:  acc_q  <= ACC_W'(val_rdata);
			ST_MUL_A: begin
				mul_hi_q <= hi_prod[ACC_W-1:0];
				mul_lo_q <= lo_prod[32:16];
			end
			ST_MUL_B:  acc_q <= mul_hi_q + ACC_W'(mul_lo_q);
			ST_TD_R:   acc_q <= td_r;
			ST_TD_OLD: acc_q <= td_old;
			ST_NV: begin
				res_q.chosen_action <= '0;
				res_q.explored      <= 1'b0;
				res_q.upd_value     <= OUT_VAL_W'(ACC_W'(nv));
			end
			default: ;
		endcase
	end

endmodule

// File: rtl/sarsa_q_table_engine_top.sv
// ----------------------------------------------------------------------------
// sarsa_q_table_engine_top
// Tabular SARSA engine with epsilon-greedy action choice.
//
//   channel   handshake                  word
//   req       req_valid / req_stall      in_word_t  (choose or update item)
//   rsp       rsp_valid / rsp_stall      out_word_t (one result per item)
//   config    psel penable pwrite pready paddr / pwdata / prdata
//
// A choose word makes four value reads in turn on the single read port of
// the value memory. An update word makes two reads, then two passes through
// the shared Q1.16 scaling multiplier with the saturating adds between them,
// then one write. A new word is accepted only once the last one is done.
// After reset a clear sweep writes GRID_ROWS*GRID_COLS*4 value entries, one
// per cycle; req is stalled until it ends. A result held by rsp_stall does
// not block the next acceptance; it only holds the following result.
// ----------------------------------------------------------------------------
module sarsa_q_table_engine_top
	import sqte_pkg::*;
#(
	parameter int GRID_ROWS   = DEF_GRID_ROWS,
	parameter int GRID_COLS   = DEF_GRID_COLS,
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  in_word_t              req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output out_word_t             rsp,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int CELLS  = GRID_ROWS * GRID_COLS;
	localparam int CELL_W = $clog2(CELLS);
	localparam int VA_W   = CELL_W + ACT_W;

	cfg_t                          cfg;
	store_ctrl_t                   store_ctrl;
	logic [VA_W-1:0]               val_addr;
	logic signed [VALUE_WIDTH-1:0] val_wdata;
	logic signed [VALUE_WIDTH-1:0] val_rdata;
	logic [CELL_W-1:0]             vis_addr;
	logic                          vis_rdata;
	logic                          clearing;

	sqte_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sqte_store #(
		.CELLS       (CELLS),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_store (
		.clk       (clk),
		.ctrl      (store_ctrl),
		.val_addr  (val_addr),
		.val_wdata (val_wdata),
		.val_rdata (val_rdata),
		.vis_addr  (vis_addr),
		.vis_rdata (vis_rdata)
	);

	sqte_engine #(
		.GRID_ROWS   (GRID_ROWS),
		.GRID_COLS   (GRID_COLS),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.clearing   (clearing),
		.store_ctrl (store_ctrl),
		.val_addr   (val_addr),
		.val_wdata  (val_wdata),
		.val_rdata  (val_rdata),
		.vis_addr   (vis_addr),
		.vis_rdata  (vis_rdata)
	);

	// one word in flight: an accepted word makes the engine busy next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request accepted while previous word still in work");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> (req_stall && !rsp_valid))
		else $error("traffic during clear sweep");

	a_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp.upd_value != '0)) |-> (rsp.chosen_action == '0 && !rsp.explored))
		else $error("update result carries choose fields");

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the SARSA table engine. A queue-fed driver sends
// choose and update words while a shadow Q table predicts every response.
// A monitor compares each accepted response field by field. The run covers a
// short directed set with the rate registers at their extremes, then random
// phases of episode walks and noise under different sender/receiver idle mixes.
// ----------------------------------------------------------------------------
module testbench;
	import sqte_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int WALK_SPAN      = 8;
	localparam int PHASE_ITEMS    = 250;

	localparam longint VALUE_MAX = 64'sd2147483647;
	localparam longint VALUE_MIN = -VALUE_MAX - 1;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_stall;
	in_word_t              req       = '0;
	logic                  rsp_valid;
	logic                  rsp_stall = 1'b0;
	out_word_t             rsp;
	logic                  psel      = 1'b0;
	logic                  penable   = 1'b0;
	logic                  pwrite    = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr     = '0;
	logic [CFG_DATA_W-1:0] pwdata    = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	sarsa_q_table_engine_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #5 clk = ~clk;

	// shadow copy of the engine state and rate registers
	longint      q_table [4096];
	bit          visited [1024];
	logic [16:0] alpha_reg   = RST_LEARNING_RATE;
	logic [16:0] gamma_reg   = RST_DISCOUNT;
	logic [16:0] epsilon_reg = RST_EXPLORE_RATE;

	in_word_t  req_pending[$];
	out_word_t resp_expected[$];

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int errors        = 0;
	int n_choose      = 0;
	int n_update      = 0;
	int n_explored    = 0;
	int n_saturated   = 0;
	int quiet_cycles  = 0;

	logic [4:0] walk_row = '0;
	logic [4:0] walk_col = '0;

	// round(k * x / 2^16), ties toward plus infinity
	function automatic longint q16_scale(longint x, longint k);
		longint hi;
		longint lo_part;
		hi = x >>> 16;
		lo_part = (k * (x & 64'h0000_0000_0000_FFFF) + 32768) >> 16;
		return k * hi + lo_part;
	endfunction

	function automatic longint add_sat64(longint a, longint b);
		logic [64:0] sum;
		sum = {a[63], a} + {b[63], b};
		if (sum[64] != sum[63])
			return sum[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
		return sum[63:0];
	endfunction

	function automatic out_word_t compute_response(in_word_t w);
		out_word_t  res;
		logic [9:0] s;
		logic [9:0] sn;
		logic [1:0] best;
		int         a;
		longint     alpha;
		longint     gamma;
		longint     oldv;
		longint     nextv;
		longint     td;
		longint     nv;
		res = '0;
		s = {w.state_row, w.state_col};
		if (w.operation == OP_CHOOSE) begin
			n_choose++;
			if ({1'b0, w.random_fraction} < epsilon_reg || !visited[s]) begin
				res.chosen_action = w.random_action;
				res.explored = 1'b1;
				n_explored++;
			end else begin
				best = 2'd0;
				for (a = 1; a < 4; a++)
					if (q_table[{s, 2'(a)}] > q_table[{s, best}])
						best = 2'(a);
				res.chosen_action = best;
			end
		end else begin
			n_update++;
			sn = {w.next_row, w.next_col};
			alpha = (alpha_reg > ONE_Q16) ? longint'(ONE_Q16) : longint'(alpha_reg);
			gamma = (gamma_reg > ONE_Q16) ? longint'(ONE_Q16) : longint'(gamma_reg);
			visited[s] = 1'b1;
			visited[sn] = 1'b1;
			// read both before writing, so a self update sees the old value twice
			oldv = q_table[{s, w.taken_action}];
			nextv = q_table[{sn, w.next_action}];
			td = add_sat64(longint'(w.reward), q16_scale(nextv, gamma));
			td = add_sat64(td, -oldv);
			nv = add_sat64(oldv, q16_scale(td, alpha));
			if (nv > VALUE_MAX) begin
				nv = VALUE_MAX;
				n_saturated++;
			end else if (nv < VALUE_MIN) begin
				nv = VALUE_MIN;
				n_saturated++;
			end
			q_table[{s, w.taken_action}] = nv;
			res.upd_value = nv[31:0];
		end
		return res;
	endfunction

	function automatic in_word_t random_word();
		logic [95:0] raw;
		raw = {$urandom, $urandom, $urandom};
		return in_word_t'(raw[$bits(in_word_t)-1:0]);
	endfunction

	function automatic in_word_t make_word(logic op, logic [4:0] sr, logic [4:0] sc,
			logic [1:0] ta, logic [31:0] rw, logic [4:0] nr, logic [4:0] nc,
			logic [1:0] na, logic [15:0] frac, logic [1:0] ra);
		return '{op, sr, sc, ta, rw, nr, nc, na, frac, ra};
	endfunction

	function automatic logic [31:0] pick_reward();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
		endcase
	endfunction

	task automatic queue_word(input in_word_t w);
		req_pending = {req_pending, w};
	endtask

	// one well-formed step of an episode: choose in the current cell, then
	// update it toward a following cell that becomes the current one
	task automatic push_walk_step();
		in_word_t   w;
		logic [4:0] nr;
		logic [4:0] nc;
		w = random_word();
		w.operation = OP_CHOOSE;
		w.state_row = walk_row;
		w.state_col = walk_col;
		queue_word(w);
		nr = 5'($urandom_range(0, WALK_SPAN - 1));
		nc = 5'($urandom_range(0, WALK_SPAN - 1));
		w = random_word();
		w.operation = OP_UPDATE;
		w.state_row = walk_row;
		w.state_col = walk_col;
		w.next_row = nr;
		w.next_col = nc;
		w.reward = pick_reward();
		queue_word(w);
		walk_row = nr;
		walk_col = nc;
	endtask

	// sampled at the falling edge so all rising-edge updates have settled
	task automatic wait_drained();
		do
			@(negedge clk);
		while (req_pending.size() != 0 || req_valid || resp_expected.size() != 0);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_LEARNING_RATE: alpha_reg = value[16:0];
			REG_DISCOUNT:      gamma_reg = value[16:0];
			REG_EXPLORE_RATE:  epsilon_reg = value[16:0];
			default: ;
		endcase
	endtask

	task automatic set_rates(input logic [31:0] lr, input logic [31:0] dc,
			input logic [31:0] er);
		write_register(REG_LEARNING_RATE, lr);
		write_register(REG_DISCOUNT, dc);
		write_register(REG_EXPLORE_RATE, er);
	endtask

	task automatic run_random_phase(input int send_idle, input int rsp_idle,
			input logic [31:0] lr, input logic [31:0] dc, input logic [31:0] er);
		int pushed;
		set_rates(lr, dc, er);
		send_idle_pct = send_idle;
		stall_pct = rsp_idle;
		pushed = 0;
		while (pushed < PHASE_ITEMS) begin
			if ($urandom_range(0, 99) < 75) begin
				push_walk_step();
				pushed += 2;
			end else begin
				queue_word(random_word());
				pushed++;
			end
		end
		wait_drained();
	endtask

	// driver: presents queued words, predicts each one as it is accepted
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && !req_stall)
				resp_expected = {resp_expected, compute_response(req)};
			if (!req_valid || !req_stall) begin
				if (req_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					req <= req_pending.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each accepted response against the oldest prediction
	always @(posedge clk) begin : monitor
		out_word_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (resp_expected.size() == 0) begin
					$display("%0t: response with nothing expected: %p", $time, rsp);
					errors++;
				end else begin
					want = resp_expected.pop_front();
					if (rsp.chosen_action !== want.chosen_action) begin
						$display("%0t: chosen_action expected %0d got %0d", $time,
							want.chosen_action, rsp.chosen_action);
						errors++;
					end
					if (rsp.explored !== want.explored) begin
						$display("%0t: explored expected %0d got %0d", $time,
							want.explored, rsp.explored);
						errors++;
					end
					if (rsp.upd_value !== want.upd_value) begin
						$display("%0t: upd_value expected %h got %h", $time,
							want.upd_value, rsp.upd_value);
						errors++;
					end
				end
			end
			rsp_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog, no word moved for %0d cycles", $time, quiet_cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset rates: unvisited explore, greedy ties, reward extremes, self update
		queue_word(make_word(OP_CHOOSE, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF, 3));
		queue_word(make_word(OP_UPDATE, 0, 0, 2, 32'h0001_0000, 31, 31, 3, 0, 0));
		queue_word(make_word(OP_CHOOSE, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF, 1));
		queue_word(make_word(OP_CHOOSE, 0, 0, 0, 0, 0, 0, 0, 16'h0000, 1));
		queue_word(make_word(OP_CHOOSE, 31, 31, 0, 0, 0, 0, 0, 16'hFFFF, 2));
		queue_word(make_word(OP_UPDATE, 31, 0, 3, 32'h7FFF_FFFF, 0, 0, 2, 0, 0));
		queue_word(make_word(OP_UPDATE, 0, 31, 0, 32'h8000_0000, 31, 0, 3, 0, 0));
		queue_word(make_word(OP_UPDATE, 5, 5, 1, 32'h0003_0000, 5, 5, 1, 0, 0));
		queue_word(make_word(OP_CHOOSE, 0, 31, 0, 0, 0, 0, 0, 16'hFFFF, 0));
		wait_drained();

		// unity factors drive the table into both saturation limits; never explore
		set_rates(32'd65536, 32'd65536, 32'd0);
		queue_word(make_word(OP_UPDATE, 2, 2, 0, 32'h7FFF_FFFF, 2, 2, 0, 0, 0));
		queue_word(make_word(OP_UPDATE, 2, 2, 0, 32'h7FFF_FFFF, 2, 2, 0, 0, 0));
		queue_word(make_word(OP_UPDATE, 3, 3, 0, 32'h8000_0000, 3, 3, 0, 0, 0));
		queue_word(make_word(OP_UPDATE, 3, 3, 0, 32'h8000_0000, 3, 3, 0, 0, 0));
		queue_word(make_word(OP_CHOOSE, 3, 3, 0, 0, 0, 0, 0, 16'h0000, 0));
		queue_word(make_word(OP_CHOOSE, 2, 2, 0, 0, 0, 0, 0, 16'h0000, 3));
		wait_drained();

		// zero factors leave the entry alone; epsilon above one always explores
		set_rates(32'd0, 32'd0, 32'd131071);
		queue_word(make_word(OP_UPDATE, 2, 2, 0, 32'd5, 3, 3, 0, 0, 0));
		queue_word(make_word(OP_CHOOSE, 2, 2, 0, 0, 0, 0, 0, 16'hFFFF, 3));
		wait_drained();

		// factors above one clamp to one; epsilon just under one
		set_rates(32'd131071, 32'd131071, 32'd65535);
		queue_word(make_word(OP_UPDATE, 4, 4, 2, 32'h0001_8000, 2, 2, 0, 0, 0));
		queue_word(make_word(OP_CHOOSE, 4, 4, 0, 0, 0, 0, 0, 16'hFFFF, 0));
		queue_word(make_word(OP_CHOOSE, 4, 4, 0, 0, 0, 0, 0, 16'hFFFE, 1));
		wait_drained();

		run_random_phase(0, 0, 32'd65536, 32'd58982, 32'd6554);
		run_random_phase(76, 0, 32'd32768, 32'd65536, 32'd0);
		run_random_phase(0, 76, 32'd131071, 32'd0, 32'd65536);
		run_random_phase(24, 24, $urandom_range(0, 131071), $urandom_range(0, 131071),
			$urandom_range(0, 16384));

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("checked %0d choose and %0d update words: %0d explored picks, %0d saturated writes",
			n_choose, n_update, n_explored, n_saturated);
		$display("rate registers swept through zero, one and above one, under four idle mixes");
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
